@@ rtl/x86_subset_execute_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef X86_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define X86_SUBSET_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define XSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define XSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/xse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xse_pkg
// types, opcodes and helpers for the x86 subset execute unit
// ----------------------------------------------------------------------------
package xse_pkg;

  localparam int INSTR_BYTES_DEF = 8;
  localparam int MEM_BYTES_DEF   = 65536;

  localparam logic [3:0]  STACK_REG  = 4'd4;
  localparam logic [63:0] WORD_BYTES = 64'd8;

  typedef enum logic [2:0] {
    F_ADD  = 3'd0,
    F_MOV  = 3'd1,
    F_STM  = 3'd2,
    F_LDM  = 3'd3,
    F_PUSH = 3'd4,
    F_POP  = 3'd5,
    F_CALL = 3'd6,
    F_RET  = 3'd7
  } func_t;

  localparam logic [3:0] K_EMPTY     = 4'd0;
  localparam logic [3:0] K_IMM       = 4'd1;
  localparam logic [3:0] K_REG       = 4'd2;
  localparam logic [3:0] K_MEM_I     = 4'd3;
  localparam logic [3:0] K_MEM_B     = 4'd4;
  localparam logic [3:0] K_MEM_IB    = 4'd5;
  localparam logic [3:0] K_MEM_BX    = 4'd6;
  localparam logic [3:0] K_MEM_IBX   = 4'd7;
  localparam logic [3:0] K_MEM_XS    = 4'd8;
  localparam logic [3:0] K_MEM_IXS   = 4'd9;
  localparam logic [3:0] K_MEM_BXS   = 4'd10;
  localparam logic [3:0] K_MEM_IBXS  = 4'd11;

  // first declared member sits in the highest bits
  typedef struct packed {
    logic [63:0] dst_imm;
    logic [3:0]  dst_scale;
    logic [3:0]  dst_index;
    logic [3:0]  dst_base;
    logic [3:0]  dst_kind;
    logic [63:0] src_imm;
    logic [3:0]  src_scale;
    logic [3:0]  src_index;
    logic [3:0]  src_base;
    logic [3:0]  src_kind;
    func_t       func;
  } instr_t;

  typedef struct packed {
    logic [63:0] mem_value;
    logic [15:0] mem_address;
    logic        mem_written;
    logic [63:0] reg_value;
    logic [3:0]  reg_target;
    logic        reg_written;
    logic [63:0] next_pc;
  } result_t;

  function automatic logic is_mem(input logic [3:0] k);
    is_mem = (k inside {[K_MEM_I:K_MEM_IBXS]});
  endfunction

  function automatic logic [63:0] ea_calc(input logic [3:0] k, input logic [63:0] b,
                                          input logic [63:0] x, input logic [3:0] sc,
                                          input logic [63:0] imm);
    logic [63:0] s;
    s = x * {60'd0, sc};
    case (k)
      K_MEM_I:    ea_calc = imm;
      K_MEM_B:    ea_calc = b;
      K_MEM_IB:   ea_calc = imm + b;
      K_MEM_BX:   ea_calc = b + x;
      K_MEM_IBX:  ea_calc = b + x + imm;
      K_MEM_XS:   ea_calc = s;
      K_MEM_IXS:  ea_calc = s + imm;
      K_MEM_BXS:  ea_calc = b + s;
      K_MEM_IBXS: ea_calc = b + s + imm;
      default:    ea_calc = 64'd0;
    endcase
  endfunction

endpackage

@@ rtl/xse_bytemem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xse_bytemem
// byte memory as eight byte lanes, unaligned 8-byte access, clear after reset
// ----------------------------------------------------------------------------
module xse_bytemem import xse_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         busy,
  input  logic                         acc_we,
  input  logic [$clog2(MEM_BYTES)-1:0] acc_addr,
  input  logic [63:0]                  acc_wd,
  output logic [63:0]                  rd_data
);

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int RW   = AW - 3;
  localparam int ROWS = MEM_BYTES / 8;

  logic          clr_r;
  logic [RW-1:0] clr_row_r;
  logic [2:0]    off_r;
  logic [7:0]    lane_q [8];

  assign busy = clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_row_r <= '0;
    end else if (clr_r) begin
      clr_row_r <= clr_row_r + 1'b1;
      if (&clr_row_r) clr_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    off_r <= acc_addr[2:0];
  end

  for (genvar l = 0; l < 8; l++) begin : g_lane
    logic [7:0]    lane_mem [ROWS];
    logic [RW-1:0] row;
    logic [2:0]    bsel;
    logic [7:0]    wbyte;

    // lanes below the start offset belong to the next row
    always_comb begin
      bsel  = 3'(l) - acc_addr[2:0];
      wbyte = acc_wd[8*bsel +: 8];
      if (clr_r) row = clr_row_r;
      else row = acc_addr[AW-1:3] + RW'(3'(l) < acc_addr[2:0]);
    end

    always_ff @(posedge clk) begin
      if (clr_r || acc_we) lane_mem[row] <= clr_r ? 8'd0 : wbyte;
      lane_q[l] <= lane_mem[row];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rd_data[8*i +: 8] = lane_q[3'(i) + off_r];
    end
  end

endmodule

@@ rtl/x86_subset_execute_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_subset_execute_unit
// executes decoded add, mov, load, store, push, pop, call and ret instructions
// ----------------------------------------------------------------------------
// One instruction enters per in_ beat; one result leaves per out_ beat, in
// order. The register file sits in synchronous memories read as the beat is
// accepted; the next stage forms addresses and executes. Register-only ops,
// stores, push and call finish there: a new beat can enter every cycle and
// the result is queued in the cycle after acceptance. Load, pop and ret also
// read the byte memory, whose read is registered, so they finish in the next
// cycle, in the load completion stage; no new beat enters while one of them
// is in the execute stage. Register writes reach the next instruction through
// a bypass, no bubble. Results go through a 4-entry output queue; when
// out_tready is low the queue fills and in_tready drops once it cannot
// hold every instruction in flight. After reset all registers and the pc
// read zero; the byte memory is cleared one 8-byte row per cycle,
// MEM_BYTES/8 rows (8192 by default), with in_tready low until it is done.
// ----------------------------------------------------------------------------
module x86_subset_execute_unit import xse_pkg::*; #(
  parameter int INSTR_BYTES = INSTR_BYTES_DEF,
  parameter int MEM_BYTES   = MEM_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func, src_kind, src_base, src_index, src_scale, src_imm,
  // dst_kind, dst_base, dst_index, dst_scale, dst_imm, zero pad
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // next_pc, reg_written, reg_target, reg_value, mem_written, mem_address,
  // mem_value, zero pad
  output logic [215:0] out_tdata
);

  localparam int AW     = $clog2(MEM_BYTES);
  localparam int QDEPTH = 4;
  localparam int QW     = $clog2(QDEPTH);

  typedef struct packed {
    logic        rw;
    logic [3:0]  rt;
    logic [63:0] rv;
    logic        sp_we;
    logic [63:0] sp_val;
  } wb_t;

  instr_t in_i;
  logic   in_acc;
  assign in_i   = instr_t'(in_tdata[162:0]);
  assign in_acc = in_tvalid && in_tready;

  // architectural state kept in flops
  logic [63:0] sp_r;
  logic [63:0] pc_r;
  logic [15:0] rf_vld_r;

  // register file copies, two read ports each
  logic [63:0] rf_a [16];
  logic [63:0] rf_b [16];
  logic [63:0] rd_sb_r, rd_si_r, rd_db_r, rd_di_r;
  logic [3:0]  byp_hit_r;
  logic [63:0] byp_d_r;

  logic        rf_we;
  logic [3:0]  rf_wa;
  logic [63:0] rf_wd;

  logic   s1_v_r;
  instr_t s1_i_r;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_a[rf_wa] <= rf_wd;
      rf_b[rf_wa] <= rf_wd;
    end
    rd_sb_r   <= rf_a[in_i.src_base];
    rd_si_r   <= rf_a[in_i.src_index];
    rd_db_r   <= rf_b[in_i.dst_base];
    rd_di_r   <= rf_b[in_i.dst_index];
    byp_hit_r <= {rf_we && (rf_wa == in_i.dst_index), rf_we && (rf_wa == in_i.dst_base),
                  rf_we && (rf_wa == in_i.src_index), rf_we && (rf_wa == in_i.src_base)};
    byp_d_r   <= rf_wd;
    s1_i_r    <= in_i;
  end

  function automatic logic [63:0] pick(input logic [3:0] a, input logic hit,
                                       input logic [63:0] md, input logic [63:0] sp,
                                       input logic [63:0] bd, input logic [15:0] vld);
    if (a == STACK_REG) pick = sp;
    else if (hit) pick = bd;
    else if (vld[a]) pick = md;
    else pick = 64'd0;
  endfunction

  // ---------------- execute stage ----------------
  logic [63:0] sb, si, db, di, ea_s, ea_d, sv, pc_inc, sp_dec;
  logic        s1_load;
  result_t     s1_res;
  wb_t         s1_wb;
  logic        bm_we;
  logic [63:0] bm_va;
  logic        bm_busy;
  logic [63:0] bm_rd;

  always_comb begin
    sb      = pick(s1_i_r.src_base, byp_hit_r[0], rd_sb_r, sp_r, byp_d_r, rf_vld_r);
    si      = pick(s1_i_r.src_index, byp_hit_r[1], rd_si_r, sp_r, byp_d_r, rf_vld_r);
    db      = pick(s1_i_r.dst_base, byp_hit_r[2], rd_db_r, sp_r, byp_d_r, rf_vld_r);
    di      = pick(s1_i_r.dst_index, byp_hit_r[3], rd_di_r, sp_r, byp_d_r, rf_vld_r);
    ea_s    = ea_calc(s1_i_r.src_kind, sb, si, s1_i_r.src_scale, s1_i_r.src_imm);
    ea_d    = ea_calc(s1_i_r.dst_kind, db, di, s1_i_r.dst_scale, s1_i_r.dst_imm);
    pc_inc  = pc_r + 64'(INSTR_BYTES);
    sp_dec  = sp_r - WORD_BYTES;
    s1_load = (s1_i_r.func inside {F_LDM, F_POP, F_RET});

    if (s1_i_r.src_kind == K_IMM) sv = s1_i_r.src_imm;
    else if (s1_i_r.src_kind == K_REG) sv = sb;
    else if (is_mem(s1_i_r.src_kind)) sv = ea_s;
    else sv = 64'd0;

    s1_res         = '0;
    s1_res.next_pc = pc_inc;
    bm_we          = 1'b0;
    bm_va          = 64'd0;
    case (s1_i_r.func)
      F_ADD, F_MOV: begin
        if (s1_i_r.dst_kind == K_REG) begin
          s1_res.reg_written = 1'b1;
          s1_res.reg_target  = s1_i_r.dst_base;
          s1_res.reg_value   = (s1_i_r.func == F_ADD) ? db + sv : sv;
        end
      end
      F_STM: begin
        if (is_mem(s1_i_r.dst_kind)) begin
          bm_we              = 1'b1;
          bm_va              = ea_d;
          s1_res.mem_written = 1'b1;
          s1_res.mem_value   = sv;
        end
      end
      F_PUSH, F_CALL: begin
        bm_we              = 1'b1;
        bm_va              = sp_dec;
        s1_res.mem_written = 1'b1;
        s1_res.mem_value   = (s1_i_r.func == F_CALL) ? pc_inc : sv;
        s1_res.reg_written = 1'b1;
        s1_res.reg_target  = STACK_REG;
        s1_res.reg_value   = sp_dec;
        if (s1_i_r.func == F_CALL) s1_res.next_pc = sv;
      end
      F_LDM: bm_va = ea_s;
      default: bm_va = sp_r;
    endcase
    s1_res.mem_address = bm_we ? 16'(bm_va & 64'(MEM_BYTES - 1)) : 16'd0;

    s1_wb.rw     = s1_res.reg_written;
    s1_wb.rt     = s1_res.reg_target;
    s1_wb.rv     = s1_res.reg_value;
    s1_wb.sp_we  = s1_res.reg_written && (s1_res.reg_target == STACK_REG);
    s1_wb.sp_val = s1_res.reg_value;
  end

  xse_bytemem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .busy     (bm_busy),
    .acc_we   (s1_v_r && bm_we),
    .acc_addr (bm_va[AW-1:0]),
    .acc_wd   (s1_res.mem_value),
    .rd_data  (bm_rd)
  );

  // ---------------- load completion stage ----------------
  logic        s2_v_r;
  func_t       s2_func_r;
  logic        s2_ld_ok_r;
  logic        s2_src_reg_r;
  logic [3:0]  s2_sbase_r;
  logic [3:0]  s2_dbase_r;
  logic [63:0] s2_sp_r;
  logic [63:0] s2_pc_inc_r;
  result_t     s2_res;
  wb_t         s2_wb;

  always_ff @(posedge clk) begin
    s2_func_r    <= s1_i_r.func;
    s2_ld_ok_r   <= is_mem(s1_i_r.src_kind) && (s1_i_r.dst_kind == K_REG);
    s2_src_reg_r <= (s1_i_r.src_kind == K_REG);
    s2_sbase_r   <= s1_i_r.src_base;
    s2_dbase_r   <= s1_i_r.dst_base;
    s2_sp_r      <= sp_r;
    s2_pc_inc_r  <= pc_inc;
  end

  always_comb begin
    s2_res         = '0;
    s2_res.next_pc = s2_pc_inc_r;
    s2_wb.sp_we    = 1'b0;
    s2_wb.sp_val   = s2_sp_r + WORD_BYTES;
    case (s2_func_r)
      F_LDM: begin
        if (s2_ld_ok_r) begin
          s2_res.reg_written = 1'b1;
          s2_res.reg_target  = s2_dbase_r;
          s2_res.reg_value   = bm_rd;
          // a load into the stack pointer
          s2_wb.sp_we        = (s2_dbase_r == STACK_REG);
          s2_wb.sp_val       = bm_rd;
        end
      end
      F_POP: begin
        s2_res.reg_written = 1'b1;
        s2_wb.sp_we        = 1'b1;
        if (s2_src_reg_r && s2_sbase_r != STACK_REG) begin
          s2_res.reg_target = s2_sbase_r;
          s2_res.reg_value  = bm_rd;
        end else if (s2_src_reg_r) begin
          s2_res.reg_target = STACK_REG;
          s2_res.reg_value  = bm_rd + WORD_BYTES;
          s2_wb.sp_val      = bm_rd + WORD_BYTES;
        end else begin
          s2_res.reg_target = STACK_REG;
          s2_res.reg_value  = s2_sp_r + WORD_BYTES;
        end
      end
      default: begin
        s2_res.next_pc     = bm_rd;
        s2_res.reg_written = 1'b1;
        s2_res.reg_target  = STACK_REG;
        s2_res.reg_value   = s2_sp_r + WORD_BYTES;
        s2_wb.sp_we        = 1'b1;
      end
    endcase
    s2_wb.rw = s2_res.reg_written;
    s2_wb.rt = s2_res.reg_target;
    s2_wb.rv = s2_res.reg_value;
  end

  // ---------------- write back ----------------
  // the two stages never finish in the same cycle
  wb_t     wb;
  logic    res_push;
  result_t res;

  always_comb begin
    res_push = s2_v_r || (s1_v_r && !s1_load);
    res      = s2_v_r ? s2_res : s1_res;
    wb       = s2_v_r ? s2_wb : s1_wb;
    rf_we    = res_push && wb.rw && (wb.rt != STACK_REG);
    rf_wa    = wb.rt;
    rf_wd    = wb.rv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      sp_r     <= 64'd0;
      pc_r     <= 64'd0;
      rf_vld_r <= '0;
    end else begin
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r && s1_load;
      if (res_push) begin
        pc_r <= res.next_pc;
        if (wb.sp_we) sp_r <= wb.sp_val;
      end
      if (rf_we) rf_vld_r[rf_wa] <= 1'b1;
    end
  end

  // ---------------- output queue ----------------
  result_t       q_mem [QDEPTH];
  logic [QW-1:0] q_wp_r, q_rp_r;
  logic [QW:0]   q_cnt_r;
  logic [QW+1:0] occ;
  logic          q_pop;

  assign q_pop      = out_tvalid && out_tready;
  assign out_tvalid = (q_cnt_r != '0);
  assign out_tdata  = {2'b00, q_mem[q_rp_r]};
  assign occ        = {1'b0, q_cnt_r} + (QW+2)'(s1_v_r) + (QW+2)'(s2_v_r);
  assign in_tready  = !bm_busy && !(s1_v_r && s1_load) && (occ < (QW+2)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (res_push) q_mem[q_wp_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (res_push) q_wp_r <= q_wp_r + 1'b1;
      if (q_pop) q_rp_r <= q_rp_r + 1'b1;
      q_cnt_r <= q_cnt_r + (QW+1)'(res_push) - (QW+1)'(q_pop);
    end
  end

endmodule

@@ rtl/xse_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xse_checker
// port-level checks on the execute unit, attached by bind
// ----------------------------------------------------------------------------
`include "x86_subset_execute_unit_assert.svh"

module xse_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [167:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [215:0] out_tdata
);

  `XSE_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result beat dropped")
  `XSE_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "stalled beat changed")
  // memory clear keeps input closed right after reset
  `XSE_ASSERT_IMP(a_clear_after_reset, $past(!rst_n), !in_tready, "input open during clear")
  // fields of a write that did not happen read zero
  `XSE_ASSERT_IMP(a_no_reg_zero, out_tvalid && !out_tdata[64], out_tdata[132:65] == 68'd0, "reg fields not zero")
  `XSE_ASSERT_IMP(a_no_mem_zero, out_tvalid && !out_tdata[133], out_tdata[213:134] == 80'd0, "mem fields not zero")

endmodule

bind x86_subset_execute_unit xse_checker u_xse_checker (.*);

@@ tb/sv/x86_subset_execute_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_subset_execute_unit_test
// drives decoded instructions into the execute unit and checks every result
// beat against a model of registers, pc and byte memory, or a typed row
// ----------------------------------------------------------------------------
module x86_subset_execute_unit_test;
  import xse_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [215:0] out_tdata;

  x86_subset_execute_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  typedef struct {
    logic [2:0]  func;
    logic [3:0]  kind [2];
    logic [3:0]  base [2];
    logic [3:0]  index [2];
    logic [3:0]  scale [2];
    logic [63:0] imm [2];
  } insn_t;

  typedef struct {
    logic [63:0] next_pc;
    logic        reg_written;
    logic [3:0]  reg_target;
    logic [63:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [63:0] mem_value;
  } outcome_t;

  logic [63:0] gpr [16];
  logic [63:0] pc;
  logic [7:0]  ram [65536];
  outcome_t    pending [$];
  int          errors;
  int          cycles;
  int          in_idle;
  int          out_idle;

  function automatic logic [63:0] load_word(logic [63:0] a);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = ram[16'(a + i)];
    return v;
  endfunction

  function automatic logic mem_form(logic [3:0] k);
    return k >= K_MEM_I && k <= K_MEM_IBXS;
  endfunction

  function automatic logic [63:0] address_of(insn_t t, int o);
    logic [63:0] b, x, s;
    b = gpr[t.base[o]];
    x = gpr[t.index[o]];
    s = x * {60'd0, t.scale[o]};
    case (t.kind[o])
      K_MEM_I:    return t.imm[o];
      K_MEM_B:    return b;
      K_MEM_IB:   return t.imm[o] + b;
      K_MEM_BX:   return b + x;
      K_MEM_IBX:  return b + x + t.imm[o];
      K_MEM_XS:   return s;
      K_MEM_IXS:  return s + t.imm[o];
      K_MEM_BXS:  return b + s;
      K_MEM_IBXS: return b + s + t.imm[o];
      default:    return 64'd0;
    endcase
  endfunction

  // executes one instruction on the model state
  function automatic outcome_t execute(insn_t t);
    outcome_t r;
    logic [63:0] sv, sp, v;
    r = '{default: '0};
    r.next_pc = pc + 64'd8;
    sp = gpr[STACK_REG];
    if (t.kind[0] == K_IMM) sv = t.imm[0];
    else if (t.kind[0] == K_REG) sv = gpr[t.base[0]];
    else sv = address_of(t, 0);
    case (func_t'(t.func))
      F_ADD: if (t.kind[1] == K_REG) begin
        r.reg_written = 1; r.reg_target = t.base[1]; r.reg_value = gpr[t.base[1]] + sv;
      end
      F_MOV: if (t.kind[1] == K_REG) begin
        r.reg_written = 1; r.reg_target = t.base[1]; r.reg_value = sv;
      end
      F_STM: if (mem_form(t.kind[1])) begin
        r.mem_written = 1; r.mem_address = 16'(address_of(t, 1)); r.mem_value = sv;
      end
      F_LDM: if (mem_form(t.kind[0]) && t.kind[1] == K_REG) begin
        r.reg_written = 1; r.reg_target = t.base[1];
        r.reg_value = load_word(address_of(t, 0));
      end
      F_PUSH, F_CALL: begin
        r.mem_written = 1; r.mem_address = 16'(sp - 64'd8);
        r.mem_value = (t.func == F_PUSH) ? sv : r.next_pc;
        r.reg_written = 1; r.reg_target = STACK_REG; r.reg_value = sp - 64'd8;
        if (t.func == F_CALL) r.next_pc = sv;
      end
      F_POP: begin
        v = load_word(sp);
        gpr[STACK_REG] = sp + 64'd8;
        r.reg_written = 1;
        if (t.kind[0] == K_REG && t.base[0] != STACK_REG) begin
          r.reg_target = t.base[0]; r.reg_value = v;
        end else if (t.kind[0] == K_REG) begin
          r.reg_target = STACK_REG; r.reg_value = v + 64'd8;
        end else begin
          r.reg_target = STACK_REG; r.reg_value = sp + 64'd8;
        end
      end
      default: begin
        r.next_pc = load_word(sp);
        r.reg_written = 1; r.reg_target = STACK_REG; r.reg_value = sp + 64'd8;
      end
    endcase
    if (r.mem_written)
      for (int i = 0; i < 8; i++) ram[r.mem_address + 16'(i)] = r.mem_value[8*i +: 8];
    if (r.reg_written) gpr[r.reg_target] = r.reg_value;
    pc = r.next_pc;
    return r;
  endfunction

  function automatic logic [167:0] pack_insn(insn_t t);
    return {t.imm[1], t.scale[1], t.index[1], t.base[1], t.kind[1],
            t.imm[0], t.scale[0], t.index[0], t.base[0], t.kind[0], t.func};
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // result side: check each beat against the oldest expectation
  always @(posedge clk) begin
    outcome_t w, g;
    if (rst_n && out_tvalid && out_tready) begin
      g.next_pc = out_tdata[63:0];
      g.reg_written = out_tdata[64];
      g.reg_target = out_tdata[68:65];
      g.reg_value = out_tdata[132:69];
      g.mem_written = out_tdata[133];
      g.mem_address = out_tdata[149:134];
      g.mem_value = out_tdata[213:150];
      if (pending.size() == 0) report("unexpected beat", g.next_pc, 0);
      else begin
        w = pending.pop_front();
        if (g.next_pc !== w.next_pc) report("next_pc", g.next_pc, w.next_pc);
        if (g.reg_written !== w.reg_written) report("reg_written", g.reg_written, w.reg_written);
        if (g.reg_target !== w.reg_target) report("reg_target", g.reg_target, w.reg_target);
        if (g.reg_value !== w.reg_value) report("reg_value", g.reg_value, w.reg_value);
        if (g.mem_written !== w.mem_written) report("mem_written", g.mem_written, w.mem_written);
        if (g.mem_address !== w.mem_address) report("mem_address", g.mem_address, w.mem_address);
        if (g.mem_value !== w.mem_value) report("mem_value", g.mem_value, w.mem_value);
      end
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= out_idle);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("x86_subset_execute_unit_test: errors");
      $finish;
    end
  end

  // sends one beat; the typed expectation, if given, overrides the model
  // valid stays high into the next beat unless the sender idles
  task automatic send(insn_t t, logic typed, outcome_t want);
    outcome_t p;
    while ($urandom_range(99) < in_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= pack_insn(t);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = execute(t);
    pending.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  function automatic insn_t make(logic [2:0] f, logic [3:0] sk, logic [3:0] sb,
                                 logic [63:0] si, logic [3:0] dk, logic [3:0] db,
                                 logic [63:0] di);
    insn_t t;
    t.func = f;
    t.kind[0] = sk; t.base[0] = sb; t.index[0] = 4'd3; t.scale[0] = 4'd2; t.imm[0] = si;
    t.kind[1] = dk; t.base[1] = db; t.index[1] = 4'd5; t.scale[1] = 4'd8; t.imm[1] = di;
    return t;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = '0;
      1: v = '1;
      2: v = 64'($urandom_range(64)) - 64'd32;
      3: v = {48'd0, v[15:0]};
      default: ;
    endcase
    return v;
  endfunction

  function automatic insn_t random_insn();
    insn_t t;
    t.func = 3'($urandom_range(7));
    for (int o = 0; o < 2; o++) begin
      t.kind[o] = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(11));
      t.base[o] = ($urandom_range(3) == 0) ? STACK_REG : 4'($urandom);
      t.index[o] = 4'($urandom);
      t.scale[o] = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(8));
      t.imm[o] = rand64();
    end
    // keep stack and pointers mostly sane so loads meet stored data
    if ($urandom_range(3) != 0 && t.func != F_CALL) t.kind[1] = K_REG;
    if (t.func == F_LDM && $urandom_range(3) != 0) t.kind[0] = K_MEM_B;
    return t;
  endfunction

  insn_t    table_in [$];
  outcome_t table_out [$];
  logic     table_typed [$];

  task automatic row(insn_t t, logic typed, outcome_t w);
    table_in.push_back(t);
    table_typed.push_back(typed);
    table_out.push_back(w);
  endtask

  initial begin
    outcome_t none;
    none = '{default: '0};
    errors = 0;
    cycles = 0;
    in_idle = 35;
    out_idle = 83;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    for (int i = 0; i < 16; i++) gpr[i] = '0;
    pc = '0;
    for (int i = 0; i < 65536; i++) ram[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table: after reset, extremes, every op and corner case
    row(make(F_ADD, K_EMPTY, 0, 0, K_REG, 0, 0), 1,
        '{64'd8, 1, 4'd0, 64'd0, 0, 16'd0, 64'd0});
    row(make(F_MOV, K_IMM, 0, '1, K_REG, 1, 0), 1,
        '{64'd16, 1, 4'd1, '1, 0, 16'd0, 64'd0});
    row(make(F_ADD, K_REG, 1, 0, K_REG, 1, 0), 0, none);
    row(make(F_MOV, K_IMM, 0, 64'h1000, K_REG, STACK_REG, 0), 0, none);
    row(make(F_PUSH, K_REG, STACK_REG, 0, K_EMPTY, 0, 0), 0, none);
    row(make(F_PUSH, K_IMM, 0, 64'h0123456789abcdef, K_EMPTY, 0, 0), 0, none);
    row(make(F_POP, K_REG, 7, 0, K_EMPTY, 0, 0), 0, none);
    row(make(F_POP, K_REG, STACK_REG, 0, K_EMPTY, 0, 0), 0, none);
    row(make(F_MOV, K_IMM, 0, 64'h2000, K_REG, STACK_REG, 0), 0, none);
    row(make(F_POP, K_IMM, 0, 0, K_EMPTY, 0, 0), 0, none);
    row(make(F_CALL, K_IMM, 0, 64'h400, K_EMPTY, 0, 0), 0, none);
    row(make(F_RET, K_EMPTY, 0, 0, K_EMPTY, 0, 0), 0, none);
    row(make(F_STM, K_REG, 1, 0, K_MEM_I, 0, 64'hfffc), 0, none);
    row(make(F_LDM, K_MEM_I, 0, 64'hfffc, K_REG, 9, 0), 0, none);
    row(make(F_STM, K_IMM, 0, 5, K_REG, 2, 0), 0, none);
    row(make(F_LDM, K_REG, 2, 0, K_REG, 3, 0), 0, none);
    row(make(F_ADD, K_IMM, 0, 1, K_MEM_B, 2, 0), 0, none);
    for (int k = K_MEM_I; k <= 15; k++)
      row(make(F_MOV, 4'(k), 1, 64'h10, K_REG, 10, 0), 0, none);
    foreach (table_in[i]) send(table_in[i], table_typed[i], table_out[i]);

    for (int ph = 0; ph < 3; ph++) begin
      in_idle = (ph == 0) ? 35 : (ph == 1) ? 83 : 0;
      out_idle = (ph == 0) ? 83 : (ph == 1) ? 35 : 0;
      repeat (350) send(random_insn(), 0, none);
    end
    in_tvalid <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("x86_subset_execute_unit_test: clean");
    else $display("x86_subset_execute_unit_test: errors");
    $finish;
  end

endmodule
